// ===== rtl/bmm_pkg.sv =====
// shared types, constants and bit-matrix helpers for the 16x16 boolean matrix multiplier
// no dependencies; used by every rtl file of the block
`default_nettype none

package bmm_pkg;

  localparam int unsigned MAT_N   = 16;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned LCNT_W  = 5;   // ones in one row or column, 0..16
  localparam int unsigned PROD_W  = 9;   // product of two line counts, 0..256
  localparam int unsigned PART_W  = 11;  // sum of four products, 0..1024
  localparam int unsigned CNT_W   = 13;  // total term count, 0..4096
  localparam int unsigned N_PART  = 4;
  localparam int unsigned PART_SZ = MAT_N / N_PART;
  localparam int unsigned N_STG   = 5;   // register stages, one load strobe each

  typedef logic [MAT_N-1:0][MAT_N-1:0] mat_t;      // [row][col]
  typedef logic [3:0][WORD_W-1:0]       words_t;    // blocks 00, 01, 10, 11
  typedef logic [MAT_N-1:0][LCNT_W-1:0] lcnt_arr_t;
  typedef logic [MAT_N-1:0][PROD_W-1:0] prod_arr_t;
  typedef logic [N_PART-1:0][PART_W-1:0] part_arr_t;

  typedef struct packed {
    logic [WORD_W-1:0] a_block_00;
    logic [WORD_W-1:0] a_block_01;
    logic [WORD_W-1:0] a_block_10;
    logic [WORD_W-1:0] a_block_11;
    logic [WORD_W-1:0] b_block_00;
    logic [WORD_W-1:0] b_block_01;
    logic [WORD_W-1:0] b_block_10;
    logic [WORD_W-1:0] b_block_11;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] c_block_00;
    logic [WORD_W-1:0] c_block_01;
    logic [WORD_W-1:0] c_block_10;
    logic [WORD_W-1:0] c_block_11;
    logic [CNT_W-1:0]  product_count;
  } out_t;

  // per-stage load strobes
  typedef struct packed {
    logic ld0;
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_en_t;

  // four 8x8 blocks to a row/column matrix
  function automatic mat_t unpack_mat(input words_t w);
    mat_t m;
    for (int r = 0; r < MAT_N; r++) begin
      for (int c = 0; c < MAT_N; c++) begin
        m[r][c] = w[((r >> 3) << 1) | (c >> 3)][((r & 7) << 3) | (c & 7)];
      end
    end
    return m;
  endfunction

  // row/column matrix back to four 8x8 blocks
  function automatic words_t pack_mat(input mat_t m);
    words_t w;
    for (int r = 0; r < MAT_N; r++) begin
      for (int c = 0; c < MAT_N; c++) begin
        w[((r >> 3) << 1) | (c >> 3)][((r & 7) << 3) | (c & 7)] = m[r][c];
      end
    end
    return w;
  endfunction

  // or of ands over the inner index
  function automatic mat_t bool_product(input mat_t a, input mat_t b);
    mat_t p;
    logic [MAT_N-1:0] bcol;
    for (int c = 0; c < MAT_N; c++) begin
      for (int k = 0; k < MAT_N; k++) begin
        bcol[k] = b[k][c];
      end
      for (int r = 0; r < MAT_N; r++) begin
        p[r][c] = |(a[r] & bcol);
      end
    end
    return p;
  endfunction

  function automatic logic [LCNT_W-1:0] ones16(input logic [MAT_N-1:0] v);
    logic [LCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAT_N; i++) begin
      n = n + LCNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bmm_bool.sv =====
// input register and first compute stage: boolean product and line counts
// depends on bmm_pkg
`default_nettype none

module bmm_bool (
  input  wire logic              clk,
  input  wire bmm_pkg::pipe_en_t en,
  input  wire bmm_pkg::in_t      in_data,
  output bmm_pkg::mat_t          c_mat,
  output bmm_pkg::lcnt_arr_t     col_cnt,
  output bmm_pkg::lcnt_arr_t     row_cnt
);

  bmm_pkg::mat_t      a_r;
  bmm_pkg::mat_t      b_r;
  bmm_pkg::mat_t      c_r;
  bmm_pkg::lcnt_arr_t col_r;
  bmm_pkg::lcnt_arr_t row_r;

  bmm_pkg::mat_t      c_nxt;
  bmm_pkg::lcnt_arr_t col_nxt;
  bmm_pkg::lcnt_arr_t row_nxt;
  logic [bmm_pkg::MAT_N-1:0] acol;

  always_comb begin
    c_nxt = bmm_pkg::bool_product(a_r, b_r);
    for (int k = 0; k < bmm_pkg::MAT_N; k++) begin
      for (int r = 0; r < bmm_pkg::MAT_N; r++) begin
        acol[r] = a_r[r][k];
      end
      // column k of a times row k of b gives the terms through inner index k
      col_nxt[k] = bmm_pkg::ones16(acol);
      row_nxt[k] = bmm_pkg::ones16(b_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld0) begin
      a_r <= bmm_pkg::unpack_mat({in_data.a_block_11, in_data.a_block_10,
                                  in_data.a_block_01, in_data.a_block_00});
      b_r <= bmm_pkg::unpack_mat({in_data.b_block_11, in_data.b_block_10,
                                  in_data.b_block_01, in_data.b_block_00});
    end
    if (en.ld1) begin
      c_r   <= c_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign c_mat   = c_r;
  assign col_cnt = col_r;
  assign row_cnt = row_r;

endmodule

`default_nettype wire

// ===== rtl/bmm_count.sv =====
// term count stages: line count products, partial sums, final sum
// depends on bmm_pkg
`default_nettype none

module bmm_count (
  input  wire logic                        clk,
  input  wire bmm_pkg::pipe_en_t           en,
  input  wire bmm_pkg::lcnt_arr_t          col_cnt,
  input  wire bmm_pkg::lcnt_arr_t          row_cnt,
  output logic [bmm_pkg::CNT_W-1:0]        count
);

  bmm_pkg::prod_arr_t prod_r;
  bmm_pkg::part_arr_t part_r;
  logic [bmm_pkg::CNT_W-1:0] cnt_r;

  bmm_pkg::prod_arr_t prod_nxt;
  bmm_pkg::part_arr_t part_nxt;
  logic [bmm_pkg::CNT_W-1:0] cnt_nxt;

  always_comb begin
    for (int k = 0; k < bmm_pkg::MAT_N; k++) begin
      prod_nxt[k] = bmm_pkg::PROD_W'(bmm_pkg::PROD_W'(col_cnt[k]) *
                                     bmm_pkg::PROD_W'(row_cnt[k]));
    end
    for (int j = 0; j < bmm_pkg::N_PART; j++) begin
      part_nxt[j] = '0;
      for (int i = 0; i < bmm_pkg::PART_SZ; i++) begin
        part_nxt[j] = part_nxt[j] + bmm_pkg::PART_W'(prod_r[j*bmm_pkg::PART_SZ + i]);
      end
    end
    cnt_nxt = '0;
    for (int j = 0; j < bmm_pkg::N_PART; j++) begin
      cnt_nxt = cnt_nxt + bmm_pkg::CNT_W'(part_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld2) prod_r <= prod_nxt;
    if (en.ld3) part_r <= part_nxt;
    if (en.ld4) cnt_r  <= cnt_nxt;
  end

  assign count = cnt_r;

endmodule

`default_nettype wire

// ===== rtl/boolean_matrix_multiply_16x16_unit.sv =====
// 16x16 boolean matrix product with intermediate term count, five register stages
// a result is taken by the input register, passes stages 1 to 3 in order and is shown from the output register
// throughput: one transaction per cycle while out_stall is low; set by the five-stage pipeline, no loop
// stalls fill bubbles first and hold every stage once the pipe is full
// reset (rst_n low, synchronous) empties the pipe; data registers are not cleared
// depends on bmm_pkg, bmm_bool, bmm_count
`default_nettype none

module boolean_matrix_multiply_16x16_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bmm_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bmm_pkg::out_t      out_data
);

  // stage map
  //   0: input register (unpacked to row/column form)
  //   1: boolean product and per-line ones counts
  //   2: line count products
  //   3: four partial sums
  //   4: output register

  logic [bmm_pkg::N_STG-1:0] v_r;
  logic [bmm_pkg::N_STG-1:0] v_nxt;
  logic [bmm_pkg::N_STG-1:0] rdy;
  logic [bmm_pkg::N_STG-1:0] v_in;

  bmm_pkg::pipe_en_t en;

  bmm_pkg::mat_t      c1_mat;
  bmm_pkg::lcnt_arr_t col_cnt;
  bmm_pkg::lcnt_arr_t row_cnt;
  bmm_pkg::mat_t      c2_r;
  bmm_pkg::mat_t      c3_r;
  bmm_pkg::mat_t      c4_r;
  bmm_pkg::words_t    c_words;
  logic [bmm_pkg::CNT_W-1:0] count;

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    rdy[bmm_pkg::N_STG-1] = !v_r[bmm_pkg::N_STG-1] || !out_stall;
    for (int i = bmm_pkg::N_STG-2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    v_in[0] = in_valid;
    for (int i = 1; i < bmm_pkg::N_STG; i++) begin
      v_in[i] = v_r[i-1];
    end
    for (int i = 0; i < bmm_pkg::N_STG; i++) begin
      v_nxt[i] = rdy[i] ? v_in[i] : v_r[i];
    end
  end

  always_comb begin
    en.ld0 = rdy[0] && v_in[0];
    en.ld1 = rdy[1] && v_in[1];
    en.ld2 = rdy[2] && v_in[2];
    en.ld3 = rdy[3] && v_in[3];
    en.ld4 = rdy[4] && v_in[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  bmm_bool u_bool (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .c_mat   (c1_mat),
    .col_cnt (col_cnt),
    .row_cnt (row_cnt)
  );

  bmm_count u_count (
    .clk     (clk),
    .en      (en),
    .col_cnt (col_cnt),
    .row_cnt (row_cnt),
    .count   (count)
  );

  // product bits ride along with the count stages
  always_ff @(posedge clk) begin
    if (en.ld2) c2_r <= c1_mat;
    if (en.ld3) c3_r <= c2_r;
    if (en.ld4) c4_r <= c3_r;
  end

  assign c_words = bmm_pkg::pack_mat(c4_r);

  always_comb begin
    out_data.c_block_00    = c_words[0];
    out_data.c_block_01    = c_words[1];
    out_data.c_block_10    = c_words[2];
    out_data.c_block_11    = c_words[3];
    out_data.product_count = count;
  end

  assign out_valid = v_r[bmm_pkg::N_STG-1];
  assign in_stall  = !rdy[0];

endmodule

`default_nettype wire

// ===== rtl/bmm_checker.sv =====
// port-level checks for the boolean matrix multiplier, bound to the top level
// depends on bmm_pkg and boolean_matrix_multiply_16x16_unit
`default_nettype none

module bmm_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire bmm_pkg::out_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // count never exceeds sixteen cubed
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.product_count <= 13'd4096)
    else $error("term count out of range");

  // a zero count means no product bit can be set, and the reverse
  a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.product_count == 13'd0) ==
                   (out_data.c_block_00 == 64'd0 && out_data.c_block_01 == 64'd0 &&
                    out_data.c_block_10 == 64'd0 && out_data.c_block_11 == 64'd0)))
    else $error("term count disagrees with product bits");

  // an empty pipe never stalls the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!out_valid) && $past(!in_valid) && $past(!in_valid, 2) &&
    $past(!in_valid, 3) && $past(!in_valid, 4) && $past(rst_n, 5) |-> !in_stall)
    else $error("input stalled with an empty pipe");

endmodule

bind boolean_matrix_multiply_16x16_unit bmm_checker u_bmm_checker (.*);

`default_nettype wire
